FILE: hw/rtl/sdrb_pkg.sv
// Package for the sequence-filtered receive ring buffer.
// Command and status codes, default ring depth, sequence window bit.
// No dependencies.
package sdrb_pkg;

  localparam int RING_DEPTH_DEF = 256;

  localparam int CMD_W = 2;
  localparam int SEQ_W = 8;
  localparam int LEN_W = 16;
  localparam int BYTE_W = 8;
  localparam int STAT_W = 3;
  localparam int FREE_W = 8;

  localparam logic [CMD_W-1:0] CMD_START = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP   = 2'd2;

  localparam logic [STAT_W-1:0] ST_ACCEPTED   = 3'd0;
  localparam logic [STAT_W-1:0] ST_DUPLICATE  = 3'd1;
  localparam logic [STAT_W-1:0] ST_STORED     = 3'd2;
  localparam logic [STAT_W-1:0] ST_DROPPED    = 3'd3;
  localparam logic [STAT_W-1:0] ST_READ_OK    = 3'd4;
  localparam logic [STAT_W-1:0] ST_READ_EMPTY = 3'd5;

  localparam logic [SEQ_W-1:0] SEQ_WINDOW_BIT = 8'h80;

endpackage

FILE: hw/rtl/seq_dedup_ring_receive_buffer_unit.sv
// Top level of the sequence-filtered receive ring buffer.
// Depends on sdrb_pkg, sdrb_ring, sdrb_ctrl.
//
//   channel  ports                                         handshake
//   input    in_cmd in_seq_num in_payload_len in_data_byte start & !busy
//   result   out_status out_read_data out_free_space       out_valid, one cycle
//
// Each word's result shows the cycle after acceptance.
// A pop reads the ring memory at the accepting edge; the registered read
// port holds the byte for the result, so words may follow back to back.
// busy is high during reset and the cycle after it. The receiver cannot stall.
module seq_dedup_ring_receive_buffer_unit #(
  parameter int RING_DEPTH = sdrb_pkg::RING_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [sdrb_pkg::CMD_W-1:0]    in_cmd,
  input  logic [sdrb_pkg::SEQ_W-1:0]    in_seq_num,
  input  logic [sdrb_pkg::LEN_W-1:0]    in_payload_len,
  input  logic [sdrb_pkg::BYTE_W-1:0]   in_data_byte,
  output logic                          out_valid,
  output logic [sdrb_pkg::STAT_W-1:0]   out_status,
  output logic [sdrb_pkg::BYTE_W-1:0]   out_read_data,
  output logic [sdrb_pkg::FREE_W-1:0]   out_free_space
);
  import sdrb_pkg::*;

  localparam int IDX_W = $clog2(RING_DEPTH);

  logic              busy_r;
  logic              accept;
  logic              wr_en, rd_en, pop_ok;
  logic [IDX_W-1:0]  wr_addr, rd_addr;
  logic [BYTE_W-1:0] wr_data, rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  sdrb_ctrl #(
    .RING_DEPTH (RING_DEPTH),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .cmd         (in_cmd),
    .seq_num     (in_seq_num),
    .payload_len (in_payload_len),
    .data_byte   (in_data_byte),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .res_valid   (out_valid),
    .res_status  (out_status),
    .res_pop_ok  (pop_ok),
    .res_free    (out_free_space)
  );

  sdrb_ring #(
    .RING_DEPTH (RING_DEPTH),
    .IDX_W      (IDX_W)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_read_data = pop_ok ? rd_data : '0;

  a_valid_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept))
    else $error("result without accepted word");

  a_pop_status: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_cmd == CMD_POP) |=>
      out_valid && ((out_status == ST_READ_OK) || (out_status == ST_READ_EMPTY)))
    else $error("pop did not give a read status");

  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_READ_OK) |-> (out_read_data == '0))
    else $error("read data nonzero without a pop");

  a_write_status: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_cmd == CMD_WRITE) |=>
      (out_status == ST_STORED) || (out_status == ST_DROPPED))
    else $error("payload byte gave a wrong status");

endmodule

FILE: hw/rtl/sdrb_ring.sv
// Byte ring storage: one write port, one read port, registered read data.
// Depends on sdrb_pkg.
module sdrb_ring #(
  parameter int RING_DEPTH = sdrb_pkg::RING_DEPTH_DEF,
  parameter int IDX_W = $clog2(RING_DEPTH)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [IDX_W-1:0]          wr_addr,
  input  logic [sdrb_pkg::BYTE_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [IDX_W-1:0]          rd_addr,
  output logic [sdrb_pkg::BYTE_W-1:0] rd_data
);
  import sdrb_pkg::*;

  logic [BYTE_W-1:0] mem [RING_DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/sdrb_ctrl.sv
// Control: ring pointers, duplicate filter, element byte budget, result regs.
// Depends on sdrb_pkg; drives the ports of sdrb_ring.
module sdrb_ctrl #(
  parameter int RING_DEPTH = sdrb_pkg::RING_DEPTH_DEF,
  parameter int IDX_W = $clog2(RING_DEPTH)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [sdrb_pkg::CMD_W-1:0]  cmd,
  input  logic [sdrb_pkg::SEQ_W-1:0]  seq_num,
  input  logic [sdrb_pkg::LEN_W-1:0]  payload_len,
  input  logic [sdrb_pkg::BYTE_W-1:0] data_byte,
  output logic                        wr_en,
  output logic [IDX_W-1:0]            wr_addr,
  output logic [sdrb_pkg::BYTE_W-1:0] wr_data,
  output logic                        rd_en,
  output logic [IDX_W-1:0]            rd_addr,
  output logic                        res_valid,
  output logic [sdrb_pkg::STAT_W-1:0] res_status,
  output logic                        res_pop_ok,
  output logic [sdrb_pkg::FREE_W-1:0] res_free
);
  import sdrb_pkg::*;

  localparam logic [IDX_W:0]   DEPTH_X = (IDX_W+1)'(RING_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IX = IDX_W'(RING_DEPTH - 1);

  logic [SEQ_W-1:0]  last_seq_r, last_seq_nxt;
  logic [IDX_W-1:0]  wr_idx_r, wr_idx_nxt;
  logic [IDX_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0]  budget_r, budget_nxt;
  logic              open_r, open_nxt;
  logic              valid_r;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic              pop_ok_r, pop_ok_nxt;
  logic [FREE_W-1:0] free_r, free_nxt;

  logic [SEQ_W-1:0]  seq_diff;
  logic              dup;
  logic [IDX_W:0]    space_raw, free_raw;
  logic [IDX_W-1:0]  space_now, space_after;
  logic [LEN_W-1:0]  space_ext;
  logic              empty;

  // (rd - wr - 1) mod depth, current and after this item
  always_comb begin
    space_raw = {1'b0, rd_idx_r} + DEPTH_X - {1'b0, wr_idx_r} - (IDX_W+1)'(1);
    if (space_raw >= DEPTH_X) begin
      space_raw = space_raw - DEPTH_X;
    end
    space_now = space_raw[IDX_W-1:0];
    free_raw = {1'b0, rd_idx_nxt} + DEPTH_X - {1'b0, wr_idx_nxt} - (IDX_W+1)'(1);
    if (free_raw >= DEPTH_X) begin
      free_raw = free_raw - DEPTH_X;
    end
    space_after = free_raw[IDX_W-1:0];
  end

  assign space_ext = LEN_W'(space_now);
  assign seq_diff  = last_seq_r - seq_num;
  assign dup       = (seq_num != '0) && ((seq_diff & SEQ_WINDOW_BIT) == '0);
  assign empty     = (rd_idx_r == wr_idx_r);

  always_comb begin
    last_seq_nxt = last_seq_r;
    wr_idx_nxt   = wr_idx_r;
    rd_idx_nxt   = rd_idx_r;
    budget_nxt   = budget_r;
    open_nxt     = open_r;
    status_nxt   = ST_DROPPED;
    pop_ok_nxt   = 1'b0;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    if (accept) begin
      case (cmd)
        CMD_START: begin
          if (dup) begin
            status_nxt = ST_DUPLICATE;
            open_nxt   = 1'b0;
            budget_nxt = '0;
          end else begin
            status_nxt   = ST_ACCEPTED;
            last_seq_nxt = seq_num;
            open_nxt     = 1'b1;
            budget_nxt   = (payload_len < space_ext) ? IDX_W'(payload_len) : space_now;
          end
        end
        CMD_WRITE: begin
          if (open_r && (budget_r != '0)) begin
            status_nxt = ST_STORED;
            wr_en      = 1'b1;
            wr_idx_nxt = (wr_idx_r == LAST_IX) ? '0 : wr_idx_r + IDX_W'(1);
            budget_nxt = budget_r - IDX_W'(1);
          end
        end
        CMD_POP: begin
          if (!empty) begin
            status_nxt = ST_READ_OK;
            pop_ok_nxt = 1'b1;
            rd_en      = 1'b1;
            rd_idx_nxt = (rd_idx_r == LAST_IX) ? '0 : rd_idx_r + IDX_W'(1);
          end else begin
            status_nxt = ST_READ_EMPTY;
          end
        end
        default: begin
          status_nxt = ST_DROPPED;
        end
      endcase
    end
    if (IDX_W > FREE_W && space_after > IDX_W'(255)) begin
      free_nxt = '1;
    end else begin
      free_nxt = FREE_W'(space_after);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_seq_r <= '0;
      wr_idx_r   <= '0;
      rd_idx_r   <= '0;
      budget_r   <= '0;
      open_r     <= 1'b0;
      valid_r    <= 1'b0;
    end else begin
      last_seq_r <= last_seq_nxt;
      wr_idx_r   <= wr_idx_nxt;
      rd_idx_r   <= rd_idx_nxt;
      budget_r   <= budget_nxt;
      open_r     <= open_nxt;
      valid_r    <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      pop_ok_r <= pop_ok_nxt;
      free_r   <= free_nxt;
    end
  end

  assign wr_addr    = wr_idx_r;
  assign wr_data    = data_byte;
  assign rd_addr    = rd_idx_r;
  assign res_valid  = valid_r;
  assign res_status = status_r;
  assign res_pop_ok = pop_ok_r;
  assign res_free   = free_r;

endmodule
